// ===== rtl/core/gwm_pkg.sv =====
// Package for the greedy wildcard matcher: item kinds, match modes,
// character constants and the ASCII upcase helper. No dependencies.
package gwm_pkg;

    localparam int PATTERN_DEPTH = 256;
    localparam int CHAR_WIDTH    = 16;
    localparam int DATA_W        = 16;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [DATA_W-1:0] QMARK   = 16'h003F;
    localparam logic [DATA_W-1:0] STAR    = 16'h002A;
    localparam logic [DATA_W-1:0] LOWER_A = 16'h0061;
    localparam logic [DATA_W-1:0] LOWER_Z = 16'h007A;
    localparam logic [DATA_W-1:0] CASE_OFS = 16'h0020;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_NAME   = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SEEK   = 2'd1,
        MODE_MATCH  = 2'd2,
        MODE_FAIL   = 2'd3
    } t_mode;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_item_ctl;

    function automatic logic [DATA_W-1:0] upcase(input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/gwm_front.sv =====
// Front end of the wildcard matcher: accepts stream items, upcases the
// character and holds items in a short queue. Depends on gwm_pkg.
module gwm_front #(
    parameter int CHAR_WIDTH = gwm_pkg::CHAR_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [gwm_pkg::DATA_W-1:0]  i_char,
    input  logic [1:0]                  i_op,
    output gwm_pkg::t_item_ctl          o_ctl,
    output logic [CHAR_WIDTH-1:0]       o_char,
    input  logic                        i_pop
);

    localparam int QD = gwm_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);

    gwm_pkg::t_op          r_op_q   [QD];
    logic [CHAR_WIDTH-1:0] r_char_q [QD];
    logic [PW-1:0]         r_wr_ptr;
    logic [PW-1:0]         r_rd_ptr;
    logic [CW-1:0]         r_count;
    logic [PW-1:0]         n_wr_ptr;
    logic [PW-1:0]         n_rd_ptr;
    logic [CW-1:0]         n_count;

    logic                        push;
    logic                        pop;
    logic [gwm_pkg::DATA_W-1:0]  char_ext;
    logic [gwm_pkg::DATA_W-1:0]  char_up;

    assign o_ready = (r_count != CW'(QD));
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != '0);

    // Mask to the character width, then fold ASCII lower case.
    assign char_ext = gwm_pkg::DATA_W'(i_char[CHAR_WIDTH-1:0]);
    assign char_up  = gwm_pkg::upcase(char_ext);

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op_q[r_wr_ptr]   <= gwm_pkg::t_op'(i_op);
            r_char_q[r_wr_ptr] <= char_up[CHAR_WIDTH-1:0];
        end
    end

    assign o_ctl.valid = (r_count != '0);
    assign o_ctl.op    = r_op_q[r_rd_ptr];
    assign o_char      = r_char_q[r_rd_ptr];

endmodule

// ===== rtl/core/gwm_back.sv =====
// Back end of the wildcard matcher: pattern store, match sequencer and
// result register. Depends on gwm_pkg.
module gwm_back #(
    parameter int PATTERN_DEPTH = gwm_pkg::PATTERN_DEPTH,
    parameter int CHAR_WIDTH    = gwm_pkg::CHAR_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gwm_pkg::t_item_ctl    i_ctl,
    input  logic [CHAR_WIDTH-1:0] i_char,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_matched,
    output logic                  o_truncated
);

    localparam int AW = $clog2(PATTERN_DEPTH);
    localparam int LW = $clog2(PATTERN_DEPTH + 1);
    localparam logic [CHAR_WIDTH-1:0] QMARK = gwm_pkg::QMARK[CHAR_WIDTH-1:0];
    localparam logic [CHAR_WIDTH-1:0] STAR  = gwm_pkg::STAR[CHAR_WIDTH-1:0];

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SKRD = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    logic [CHAR_WIDTH-1:0] mem [PATTERN_DEPTH];
    logic [CHAR_WIDTH-1:0] r_rd_data;

    t_state                r_state,  n_state;
    gwm_pkg::t_mode        r_mode,   n_mode;
    logic [LW-1:0]         r_len,    n_len;
    logic [LW-1:0]         r_pos,    n_pos;
    logic [CHAR_WIDTH-1:0] r_sought, n_sought;
    logic [CHAR_WIDTH-1:0] r_char,   n_char;
    logic                  r_trunc,  n_trunc;
    logic                  r_end,    n_end;
    logic                  r_res,    n_res;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_m,  n_out_m;
    logic                  r_out_t,  n_out_t;

    logic                  we;
    logic                  pos_end;
    logic                  out_free;
    logic                  is_wild;

    assign pos_end  = (r_pos >= r_len);
    assign out_free = !r_out_valid || i_ready;
    assign is_wild  = (r_rd_data == QMARK) || (r_rd_data == STAR);
    assign o_pop    = (r_state == ST_IDLE) && i_ctl.valid;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_len       = r_len;
        n_pos       = r_pos;
        n_sought    = r_sought;
        n_char      = r_char;
        n_trunc     = r_trunc;
        n_end       = r_end;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_ready;
        n_out_m     = r_out_m;
        n_out_t     = r_out_t;
        we          = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_ctl.valid) begin
                    case (i_ctl.op)
                        gwm_pkg::OP_CLEAR: begin
                            n_len    = '0;
                            n_trunc  = 1'b0;
                            n_pos    = '0;
                            n_mode   = gwm_pkg::MODE_NORMAL;
                            n_sought = '0;
                        end
                        gwm_pkg::OP_APPEND: begin
                            if (r_len < LW'(PATTERN_DEPTH)) begin
                                we    = 1'b1;
                                n_len = r_len + LW'(1);
                            end else begin
                                n_trunc = 1'b1;
                            end
                        end
                        gwm_pkg::OP_NAME: begin
                            case (r_mode)
                                gwm_pkg::MODE_SEEK: begin
                                    if (i_char == r_sought) begin
                                        n_pos  = r_pos + LW'(1);
                                        n_mode = gwm_pkg::MODE_NORMAL;
                                    end
                                end
                                gwm_pkg::MODE_NORMAL: begin
                                    if (pos_end) begin
                                        n_mode = gwm_pkg::MODE_FAIL;
                                    end else begin
                                        // Store read of r_pos is under way.
                                        n_char  = i_char;
                                        n_state = ST_RD;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        default: begin
                            case (r_mode)
                                gwm_pkg::MODE_NORMAL: begin
                                    n_end   = 1'b1;
                                    n_state = ST_SKIP;
                                end
                                gwm_pkg::MODE_MATCH: begin
                                    n_res   = 1'b1;
                                    n_state = ST_EMIT;
                                end
                                default: begin
                                    n_res   = 1'b0;
                                    n_state = ST_EMIT;
                                end
                            endcase
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_pos   = r_pos + LW'(1);
                n_state = ST_IDLE;
                if (r_rd_data == STAR) begin
                    n_end   = 1'b0;
                    n_state = ST_SKIP;
                end else if (r_rd_data != QMARK && r_rd_data != r_char) begin
                    n_mode = gwm_pkg::MODE_FAIL;
                end
            end
            ST_SKIP: begin
                if (pos_end) begin
                    if (r_end) begin
                        n_res   = 1'b1;
                        n_state = ST_EMIT;
                    end else begin
                        n_mode  = gwm_pkg::MODE_MATCH;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_SKRD;
                end
            end
            ST_SKRD: begin
                if (is_wild) begin
                    n_pos   = r_pos + LW'(1);
                    n_state = ST_SKIP;
                end else if (r_end) begin
                    n_res   = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    n_sought = r_rd_data;
                    n_mode   = gwm_pkg::MODE_SEEK;
                    n_state  = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_m     = r_res;
                    n_out_t     = r_trunc;
                    n_pos       = '0;
                    n_mode      = gwm_pkg::MODE_NORMAL;
                    n_sought    = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= gwm_pkg::MODE_NORMAL;
            r_len       <= '0;
            r_pos       <= '0;
            r_sought    <= '0;
            r_trunc     <= 1'b0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_sought    <= n_sought;
            r_trunc     <= n_trunc;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_res   <= n_res;
        r_out_m <= n_out_m;
        r_out_t <= n_out_t;
    end

    // Pattern store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_len[AW-1:0]] <= i_char;
        end
        r_rd_data <= mem[r_pos[AW-1:0]];
    end

    assign o_valid     = r_out_valid;
    assign o_matched   = r_out_m;
    assign o_truncated = r_out_t;

endmodule

// ===== rtl/core/greedy_wildcard_matcher.sv =====
// Top level of the greedy wildcard matcher: stream ports, front queue and
// back-end sequencer. Depends on gwm_pkg, gwm_front and gwm_back.
//
// Slave items carry an op in s_axis_tuser and a character in s_axis_tdata.
// Load a pattern with a clear item and one append per character, stream name
// characters, then send end of name. Only end of name produces a master item:
// bit 0 of m_axis_tdata is the match flag, bit 1 is set when appends
// overflowed the store since the last clear. Only ASCII a..z fold to upper case.
//
// A four-item queue takes one item per cycle while it has room; an accepted
// item is registered in the queue before the sequencer sees it. The sequencer
// takes clear, append, seeking and decided name characters in its idle state;
// a name character compared against the store passes through a read state, and
// one that meets a '*' then walks the wildcards after it up to a literal or the
// end. End of name emits at once when decided, else first walks the trailing
// wildcards; the result is registered when the emit state finds the output free.
//
// Synchronous reset (i_rst_n low) empties the pattern and the queue; store
// contents are kept. A stalled result holds in its register; the sequencer
// stalls only when a second result is ready, and the input when the queue fills.
module greedy_wildcard_matcher #(
    parameter int PATTERN_DEPTH = gwm_pkg::PATTERN_DEPTH,
    parameter int CHAR_WIDTH    = gwm_pkg::CHAR_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] character
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] matched, [1] pattern_truncated, [7:2] zero
);

    gwm_pkg::t_item_ctl    q_ctl;
    logic [CHAR_WIDTH-1:0] q_char;
    logic                  q_pop;
    logic                  res_matched;
    logic                  res_truncated;

    // Accept, upcase and queue items.
    gwm_front #(
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_char  (s_axis_tdata),
        .i_op    (s_axis_tuser),
        .o_ctl   (q_ctl),
        .o_char  (q_char),
        .i_pop   (q_pop)
    );

    // Run the pattern store and the greedy match sequencer.
    gwm_back #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .CHAR_WIDTH    (CHAR_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (q_ctl),
        .i_char      (q_char),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_matched   (res_matched),
        .o_truncated (res_truncated)
    );

    assign m_axis_tdata = {6'b0, res_truncated, res_matched};

endmodule

// ===== tb/greedy_wildcard_matcher_tb.sv =====
// Self-checking testbench for greedy_wildcard_matcher: directed and random
// pattern/name streams, checked against a built-in predictor of the matcher.
// Depends on gwm_pkg (item kinds, match modes, character constants) and the RTL.
module greedy_wildcard_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Quiet cycles tolerated before the run is declared hung. The slowest
    // legal gap is an end-of-name walking ~254 stars behind a full queue
    // while the receiver is held off for a long stretch.
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic matched;
        logic truncated;
    } t_verdict;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] character
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [0] matched, [1] pattern_truncated, [7:2] zero

    // Predictor state: pattern store, compare position, mode and flags.
    logic [15:0]    pat_mem [gwm_pkg::PATTERN_DEPTH];
    int unsigned    pat_len;
    int unsigned    pat_pos;
    gwm_pkg::t_mode mode;
    logic [15:0]    seek_char;
    logic           trunc_seen;

    t_verdict    verdict_q [$];       // match verdicts still owed by the block
    logic [15:0] stim_pattern [$];    // pattern as last loaded, for building names

    int src_idle_pct   = 16;
    int sink_idle_pct  = 67;
    int sink_hold_left = 0;
    int items_sent     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    greedy_wildcard_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fold ASCII a..z only; every other code compares exactly.
    function automatic logic [15:0] fold_case(input logic [15:0] c);
        if (c >= gwm_pkg::LOWER_A && c <= gwm_pkg::LOWER_Z) begin
            return c - gwm_pkg::CASE_OFS;
        end
        return c;
    endfunction

    function automatic logic is_wild(input logic [15:0] c);
        return (c == gwm_pkg::STAR) || (c == gwm_pkg::QMARK);
    endfunction

    // Advance past a run of '*' and '?'; reads stay below the stored length.
    function automatic void skip_wild_run();
        while (pat_pos < pat_len && is_wild(fold_case(pat_mem[pat_pos]))) begin
            pat_pos++;
        end
    endfunction

    function automatic void advance_name(input logic [15:0] raw);
        logic [15:0] c;
        logic [15:0] w;
        c = fold_case(raw);
        case (mode)
            gwm_pkg::MODE_SEEK: begin
                // Greedy seek: the first equal character ends it, no backtracking.
                if (c == seek_char) begin
                    pat_pos++;
                    mode = gwm_pkg::MODE_NORMAL;
                end
            end
            gwm_pkg::MODE_NORMAL: begin
                if (pat_pos >= pat_len) begin
                    // Name runs past the pattern.
                    mode = gwm_pkg::MODE_FAIL;
                end else begin
                    w = fold_case(pat_mem[pat_pos]);
                    pat_pos++;
                    if (w == gwm_pkg::STAR) begin
                        skip_wild_run();
                        if (pat_pos >= pat_len) begin
                            mode = gwm_pkg::MODE_MATCH;
                        end else begin
                            seek_char = fold_case(pat_mem[pat_pos]);
                            mode = gwm_pkg::MODE_SEEK;
                        end
                    end else if (w != gwm_pkg::QMARK && c != w) begin
                        mode = gwm_pkg::MODE_FAIL;
                    end
                end
            end
            default: ;   // decided: hold until end of name
        endcase
    endfunction

    function automatic void predict_item(input gwm_pkg::t_op op, input logic [15:0] ch);
        t_verdict v;
        case (op)
            gwm_pkg::OP_CLEAR: begin
                pat_len    = 0;
                trunc_seen = 1'b0;
                pat_pos    = 0;
                mode       = gwm_pkg::MODE_NORMAL;
                seek_char  = '0;
            end
            gwm_pkg::OP_APPEND: begin
                if (pat_len < gwm_pkg::PATTERN_DEPTH) begin
                    pat_mem[pat_len] = ch;
                    pat_len++;
                end else begin
                    trunc_seen = 1'b1;
                end
            end
            gwm_pkg::OP_NAME: advance_name(ch);
            default: begin
                if (mode == gwm_pkg::MODE_NORMAL) begin
                    skip_wild_run();
                    v.matched = (pat_pos >= pat_len);
                end else begin
                    v.matched = (mode == gwm_pkg::MODE_MATCH);
                end
                v.truncated = trunc_seen;
                verdict_q.push_back(v);
                pat_pos   = 0;
                mode      = gwm_pkg::MODE_NORMAL;
                seek_char = '0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one item from a falling edge; idle at random first, then hold
    // until it is taken. Valid stays high afterwards so a following call
    // can stream back to back.
    task automatic send_item(input gwm_pkg::t_op op, input logic [15:0] ch);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = ch;
        s_axis_tuser  = op;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_item(op, ch);
        items_sent++;
    endtask

    // Drop valid and hold the input until every owed verdict has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic load_pattern(input string s);
        send_item(gwm_pkg::OP_CLEAR, 16'($urandom));
        for (int i = 0; i < s.len(); i++) begin
            send_item(gwm_pkg::OP_APPEND, {8'h00, s[i]});
        end
    endtask

    task automatic send_name(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(gwm_pkg::OP_NAME, {8'h00, s[i]});
        end
        send_item(gwm_pkg::OP_END, 16'($urandom));
    endtask

    // Receiver: a pending hold-off wins; otherwise stall at random.
    always @(negedge i_clk) begin
        if (sink_hold_left > 0) begin
            sink_hold_left = sink_hold_left - 1;
            m_axis_tready  = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int expv, input int gotv);
        mismatch_count++;
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, expv, gotv);
    endtask

    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with no end-of-name pending", 0, m_axis_tdata);
            end else begin
                v = verdict_q.pop_front();
                if (m_axis_tdata[0] !== v.matched) begin
                    report_mismatch("matched", v.matched, m_axis_tdata[0]);
                end
                if (m_axis_tdata[1] !== v.truncated) begin
                    report_mismatch("pattern_truncated", v.truncated, m_axis_tdata[1]);
                end
                if (m_axis_tdata[7:2] !== 6'd0) begin
                    report_mismatch("tdata padding", 0, m_axis_tdata[7:2]);
                end
            end
        end
    end

    // Watchdog: end the run once nothing has moved on either side too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Only ASCII a..z fold; neighbors of the range and wide codes stay exact.
    task automatic test_case_folding();
        send_item(gwm_pkg::OP_CLEAR, 16'hFFFF);
        send_item(gwm_pkg::OP_APPEND, 16'h0061);        // 'a'
        send_item(gwm_pkg::OP_APPEND, 16'h005A);        // 'Z'
        send_item(gwm_pkg::OP_APPEND, 16'h0161);        // low byte 'a', not ASCII
        send_item(gwm_pkg::OP_NAME, 16'h0041);
        send_item(gwm_pkg::OP_NAME, 16'h007A);
        send_item(gwm_pkg::OP_NAME, 16'h0161);
        send_item(gwm_pkg::OP_END, 16'hFFFF);           // match
        send_item(gwm_pkg::OP_NAME, 16'h0061);
        send_item(gwm_pkg::OP_NAME, 16'h005A);
        send_item(gwm_pkg::OP_NAME, 16'h0141);          // must not fold to 0x0161
        send_item(gwm_pkg::OP_END, 16'h0000);           // mismatch
        load_pattern("`{");
        send_name("@[");                                // just outside the fold range
        send_name("`{");
    endtask

    task automatic test_wildcards();
        load_pattern("a*b");
        send_name("AxxB");
        send_name("ab");        // star eats the b, seek never ends
        send_name("aqbq");      // name runs past the pattern
        load_pattern("*?*");
        send_name("");          // empty name against all wildcards
        send_name("x");
        load_pattern("x?");
        send_name("x");         // trailing '?' against an exhausted name
    endtask

    task automatic test_name_edges();
        load_pattern("");
        send_name("");
        send_name("a");
        // Append while a name is in progress: later characters see it.
        load_pattern("a");
        send_item(gwm_pkg::OP_NAME, 16'h0041);
        send_item(gwm_pkg::OP_APPEND, 16'h0062);
        send_name("B");
        // Already decided mismatch survives a later append.
        load_pattern("a");
        send_item(gwm_pkg::OP_NAME, 16'h0062);
        send_item(gwm_pkg::OP_APPEND, 16'h0062);
        send_name("");
        // Clear abandons the name in progress.
        load_pattern("ab");
        send_item(gwm_pkg::OP_NAME, 16'h0061);
        load_pattern("c");
        send_name("c");
    endtask

    // Fill the store exactly, overflow it, and match against the kept prefix.
    task automatic test_truncation();
        load_pattern("AB");
        repeat (gwm_pkg::PATTERN_DEPTH - 2) send_item(gwm_pkg::OP_APPEND, gwm_pkg::STAR);
        repeat (4) send_item(gwm_pkg::OP_APPEND, 16'h005A);
        send_name("ab");
        send_name("A");
        send_name("ABQ");
        load_pattern("");
        send_name("");          // clear drops the overflow flag
    endtask

    // Hold the receiver off while streaming verdicts so the input stalls,
    // then pause the sender until everything is back.
    task automatic test_backpressure();
        int saved_idle;
        saved_idle    = src_idle_pct;
        src_idle_pct  = 0;
        load_pattern("?");
        sink_hold_left = 150;
        repeat (10) send_name("q");
        wait_drained();
        src_idle_pct = saved_idle;
    endtask

    function automatic logic [15:0] pick_letter();
        string alphabet;
        alphabet = "ABZabzAB@[`{";
        return {8'h00, alphabet[$urandom_range(alphabet.len() - 1)]};
    endfunction

    function automatic logic [15:0] pick_pattern_char();
        int r;
        r = $urandom_range(99);
        if (r < 22) return gwm_pkg::STAR;
        if (r < 35) return gwm_pkg::QMARK;
        if (r < 88) return pick_letter();
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_name_char();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return pick_letter();
    endfunction

    function automatic logic [15:0] flip_case(input logic [15:0] c);
        if (((c >= 16'h0041 && c <= 16'h005A)
             || (c >= gwm_pkg::LOWER_A && c <= gwm_pkg::LOWER_Z))
            && $urandom_range(1) == 1) begin
            return c ^ gwm_pkg::CASE_OFS;
        end
        return c;
    endfunction

    // One random burst: mostly a fresh pattern followed by a few names, many
    // built to fit the pattern; sometimes a stray item of any kind.
    task automatic random_burst();
        logic [15:0] name_q [$];
        logic [15:0] pc;
        int r;
        if ($urandom_range(99) < 12) begin
            send_item(gwm_pkg::t_op'($urandom_range(3)), 16'($urandom));
        end else begin
            if ($urandom_range(3) != 0) begin
                send_item(gwm_pkg::OP_CLEAR, 16'($urandom));
                stim_pattern.delete();
                repeat ($urandom_range(6)) begin
                    pc = pick_pattern_char();
                    stim_pattern.push_back(pc);
                    send_item(gwm_pkg::OP_APPEND, pc);
                end
            end
            repeat ($urandom_range(1, 3)) begin
                name_q.delete();
                if ($urandom_range(2) != 0) begin
                    foreach (stim_pattern[i]) begin
                        if (stim_pattern[i] == gwm_pkg::STAR) begin
                            repeat ($urandom_range(1, 3)) name_q.push_back(pick_name_char());
                        end else if (stim_pattern[i] == gwm_pkg::QMARK) begin
                            name_q.push_back(pick_name_char());
                        end else begin
                            name_q.push_back(flip_case(stim_pattern[i]));
                        end
                    end
                end else begin
                    repeat ($urandom_range(5)) name_q.push_back(pick_name_char());
                end
                foreach (name_q[i]) begin
                    r = $urandom_range(99);
                    if (r < 3) begin
                        pc = pick_pattern_char();
                        stim_pattern.push_back(pc);
                        send_item(gwm_pkg::OP_APPEND, pc);
                    end else if (r < 5) begin
                        stim_pattern.delete();
                        send_item(gwm_pkg::OP_CLEAR, 16'($urandom));
                    end
                    send_item(gwm_pkg::OP_NAME, name_q[i]);
                end
                send_item(gwm_pkg::OP_END, 16'($urandom));
            end
        end
    endtask

    task automatic test_random(input int quota, input int src_pct, input int sink_pct);
        int first;
        wait_drained();
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        first = items_sent;
        while (items_sent - first < quota) begin
            random_burst();
        end
    endtask

    initial begin
        pat_len    = 0;
        pat_pos    = 0;
        mode       = gwm_pkg::MODE_NORMAL;
        seek_char  = '0;
        trunc_seen = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_case_folding();
        test_wildcards();
        test_name_edges();
        test_truncation();
        test_backpressure();
        test_random(25, 16, 67);
        test_random(25, 67, 16);
        test_random(25, 0, 0);

        wait_drained();
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
